>>> rtl/dnd_pkg.sv
// Shared types and constants for the DNS name decompressor.
// Used by the channel interfaces and every rtl module but dnd_alu; depends on nothing.
package dnd_pkg;

   localparam int DATA_W  = 8;
   localparam int START_W = 9;
   localparam int TEXT_W  = 64;
   localparam int COUNT_W = 4;
   localparam int CONS_W  = 9;
   localparam int LANE_W  = 3;

   // Command codes of a request transaction.
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_EXPAND = 1'b1;

   // Label type taken from the two top bits of a length byte.
   localparam logic [1:0] LT_LABEL   = 2'b00;
   localparam logic [1:0] LT_POINTER = 2'b11;

   localparam logic [DATA_W-1:0] CHAR_DOT  = 8'h2E;
   localparam logic [DATA_W-1:0] CHAR_ESC  = 8'h5C;
   localparam logic [DATA_W-1:0] BYTE_ZERO = 8'h00;

   localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;
   localparam logic [CONS_W-1:0]  CONS_MAX   = 9'h1FF;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Byte write into the packet store.
   typedef struct packed {
      logic              en;
      logic              first;
      logic [DATA_W-1:0] data;
   } load_type;

endpackage

>>> rtl/dnd_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on dnd_pkg for field widths.
interface dnd_req_if;
   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic                         first;
   logic [dnd_pkg::DATA_W-1:0]   data_byte;
   logic [dnd_pkg::START_W-1:0]  start_offset;

   modport source (output valid, cmd, first, data_byte, start_offset, input ready);
   modport sink   (input valid, cmd, first, data_byte, start_offset, output ready);
endinterface

interface dnd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dnd_pkg::TEXT_W-1:0]   text_word;
   logic [dnd_pkg::COUNT_W-1:0]  char_count;
   logic                         last;
   logic                         status;
   logic [dnd_pkg::CONS_W-1:0]   consumed;

   modport source (output valid, text_word, char_count, last, status, consumed,
                   input ready);
   modport sink   (input valid, text_word, char_count, last, status, consumed,
                   output ready);
endinterface

>>> rtl/dnd_store.sv
// Packet store: message bytes and the loaded length, one registered read port.
// Depends on dnd_pkg for the load struct.
module dnd_store #(
   parameter int MSG_BYTES = 512
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dnd_pkg::load_type                    load,
   input  logic [$clog2(MSG_BYTES)-1:0]         rd_addr,
   output logic [dnd_pkg::DATA_W-1:0]           rd_data,
   output logic [$clog2(MSG_BYTES+1)-1:0]       msg_len
);
   localparam int AW = $clog2(MSG_BYTES);
   localparam int LW = $clog2(MSG_BYTES + 1);

   logic [dnd_pkg::DATA_W-1:0] mem [MSG_BYTES];
   logic [dnd_pkg::DATA_W-1:0] rd_data_ff;
   logic [LW-1:0]              len_ff, len_in;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;

   // A byte that arrives with the store full is dropped, unless it starts a new message.
   always_comb begin
      wr_en   = load.en && (load.first || (len_ff < LW'(MSG_BYTES)));
      wr_addr = load.first ? '0 : len_ff[AW-1:0];
      len_in  = len_ff;
      if (wr_en) begin
         len_in = load.first ? LW'(1) : len_ff + LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= load.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign msg_len = len_ff;

endmodule

>>> rtl/dnd_alu.sv
// Shared add-and-compare unit: reports whether a + b reaches the limit c.
// Standalone; the sequencer steers its operands from state.
module dnd_alu #(
   parameter int W = 16
) (
   input  logic [W-1:0] opa,
   input  logic [W-1:0] opb,
   input  logic [W-1:0] limit,
   output logic         ge
);
   logic [W:0] sum;

   assign sum = {1'b0, opa} + {1'b0, opb};
   assign ge  = sum >= {1'b0, limit};

endmodule

>>> rtl/dnd_walk.sv
// Sequencer that walks a compressed name, packs text and holds the response.
// Depends on dnd_pkg, the channel interfaces and dnd_alu.
module dnd_walk #(
   parameter int MSG_BYTES  = 512,
   parameter int NAME_LIMIT = 255
) (
   input  logic                                 clock,
   input  logic                                 reset,
   dnd_req_if.sink                              req_ch,
   dnd_rsp_if.source                            rsp_ch,
   output dnd_pkg::load_type                    load,
   output logic [$clog2(MSG_BYTES)-1:0]         rd_addr,
   input  logic [dnd_pkg::DATA_W-1:0]           rd_data,
   input  logic [$clog2(MSG_BYTES+1)-1:0]       msg_len
);
   localparam int AW        = $clog2(MSG_BYTES);
   localparam int LW        = $clog2(MSG_BYTES + 1);
   localparam int PW        = (LW > 14) ? LW : 14;
   localparam int OUT_LIMIT = (NAME_LIMIT < 256) ? NAME_LIMIT : 256;
   localparam int OCW       = $clog2(OUT_LIMIT + 1);
   localparam int CW        = $clog2(MSG_BYTES + OUT_LIMIT + 130);
   localparam int XW        = ((PW > CW) ? PW : CW) + 1;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_HEAD_CHK = 4'd1;
   localparam logic [3:0] S_HEAD     = 4'd2;
   localparam logic [3:0] S_DECODE   = 4'd3;
   localparam logic [3:0] S_LBL_DOT  = 4'd4;
   localparam logic [3:0] S_LBL_LEN  = 4'd5;
   localparam logic [3:0] S_CHR_NEXT = 4'd6;
   localparam logic [3:0] S_CHR      = 4'd7;
   localparam logic [3:0] S_ESC      = 4'd8;
   localparam logic [3:0] S_PTR      = 4'd9;
   localparam logic [3:0] S_PTR_CHK  = 4'd10;
   localparam logic [3:0] S_FINAL    = 4'd11;
   localparam logic [3:0] S_FAIL     = 4'd12;

   logic [3:0]                    state_ff, state_in;
   logic [PW-1:0]                 rp_ff, rp_in;
   logic [PW-1:0]                 start_ff, start_in;
   logic [OCW-1:0]                oc_ff, oc_in;
   logic [CW-1:0]                 chk_ff, chk_in;
   logic                          fp_valid_ff, fp_valid_in;
   logic [PW-1:0]                 fp_len_ff, fp_len_in;
   logic [dnd_pkg::TEXT_W-1:0]    acc_ff, acc_in;
   logic [dnd_pkg::LANE_W-1:0]    accn_ff, accn_in;
   logic [dnd_pkg::DATA_W-1:0]    n_ff, n_in;
   logic [5:0]                    r_ff, r_in;

   logic                          out_valid_ff, out_valid_in;
   logic [dnd_pkg::TEXT_W-1:0]    out_word_ff, out_word_in;
   logic [dnd_pkg::COUNT_W-1:0]   out_cnt_ff, out_cnt_in;
   logic                          out_last_ff, out_last_in;
   logic                          out_status_ff, out_status_in;
   logic [dnd_pkg::CONS_W-1:0]    out_cons_ff, out_cons_in;

   logic                          accept, out_free;
   logic                          push_en;
   logic [dnd_pkg::DATA_W-1:0]    push_char;
   logic [dnd_pkg::TEXT_W-1:0]    word_set;
   logic                          emit_en;
   logic [dnd_pkg::TEXT_W-1:0]    emit_word;
   logic [dnd_pkg::COUNT_W-1:0]   emit_cnt;
   logic                          emit_last, emit_status;
   logic [dnd_pkg::CONS_W-1:0]    emit_cons;
   logic [PW-1:0]                 cons_raw;
   logic [PW-1:0]                 target;

   logic [XW-1:0]                 alu_a, alu_b, alu_c;
   logic                          alu_ge;

   dnd_alu #(.W(XW)) u_alu (
      .opa   (alu_a),
      .opb   (alu_b),
      .limit (alu_c),
      .ge    (alu_ge)
   );

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign rd_addr  = rp_ff[AW-1:0];
   assign target   = PW'({n_ff[5:0], rd_data});
   assign cons_raw = fp_valid_ff ? fp_len_ff : (rp_ff - start_ff);

   always_comb begin
      load.en    = accept && (req_ch.cmd == dnd_pkg::CMD_LOAD);
      load.first = req_ch.first;
      load.data  = req_ch.data_byte;
   end

   // Operand steering for the shared compare unit.
   always_comb begin
      alu_a = XW'(rp_ff);
      alu_b = '0;
      alu_c = XW'(msg_len);
      case (state_ff)
         S_LBL_DOT: begin
            alu_a = XW'(oc_ff);
            alu_c = XW'(OUT_LIMIT);
         end
         S_LBL_LEN: begin
            alu_a = XW'(oc_ff);
            alu_b = XW'(n_ff[5:0]);
            alu_c = XW'(OUT_LIMIT);
         end
         S_CHR: begin
            alu_a = XW'(oc_ff);
            alu_b = XW'(r_ff) + XW'(2);
            alu_c = XW'(OUT_LIMIT);
         end
         S_PTR: begin
            alu_a = XW'(target);
         end
         S_PTR_CHK: begin
            alu_a = XW'(chk_ff);
         end
         default: begin
            alu_a = XW'(rp_ff);
         end
      endcase
   end

   // Character packing: a full word of eight characters leaves at once.
   always_comb begin
      word_set = acc_ff;
      word_set[{accn_ff, 3'b000} +: 8] = push_char;
   end

   always_comb begin
      state_in    = state_ff;
      rp_in       = rp_ff;
      start_in    = start_ff;
      oc_in       = oc_ff;
      chk_in      = chk_ff;
      fp_valid_in = fp_valid_ff;
      fp_len_in   = fp_len_ff;
      acc_in      = acc_ff;
      accn_in     = accn_ff;
      n_in        = n_ff;
      r_in        = r_ff;
      push_en     = 1'b0;
      push_char   = rd_data;
      emit_en     = 1'b0;
      emit_word   = '0;
      emit_cnt    = '0;
      emit_last   = 1'b1;
      emit_status = dnd_pkg::STATUS_OK;
      emit_cons   = '0;
      req_ch.ready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (accept && (req_ch.cmd == dnd_pkg::CMD_EXPAND)) begin
               rp_in       = PW'(req_ch.start_offset);
               start_in    = PW'(req_ch.start_offset);
               oc_in       = '0;
               chk_in      = '0;
               fp_valid_in = 1'b0;
               acc_in      = '0;
               accn_in     = '0;
               state_in    = S_HEAD_CHK;
            end
         end
         S_HEAD_CHK: begin
            state_in = alu_ge ? S_FAIL : S_HEAD;
         end
         S_HEAD: begin
            n_in     = rd_data;
            rp_in    = rp_ff + PW'(1);
            state_in = S_DECODE;
         end
         S_DECODE: begin
            if (n_ff == dnd_pkg::BYTE_ZERO) begin
               state_in = S_FINAL;
            end else begin
               case (n_ff[7:6])
                  dnd_pkg::LT_LABEL: begin
                     state_in = (oc_ff != '0) ? S_LBL_DOT : S_LBL_LEN;
                  end
                  dnd_pkg::LT_POINTER: begin
                     if (!fp_valid_ff) begin
                        fp_valid_in = 1'b1;
                        fp_len_in   = rp_ff - start_ff + PW'(1);
                     end
                     state_in = alu_ge ? S_FAIL : S_PTR;
                  end
                  default: begin
                     state_in = S_FAIL;
                  end
               endcase
            end
         end
         S_LBL_DOT: begin
            if (alu_ge) begin
               state_in = S_FAIL;
            end else if (out_free) begin
               push_en   = 1'b1;
               push_char = dnd_pkg::CHAR_DOT;
               state_in  = S_LBL_LEN;
            end
         end
         S_LBL_LEN: begin
            if (alu_ge) begin
               state_in = S_FAIL;
            end else begin
               chk_in   = chk_ff + CW'(n_ff[5:0]) + CW'(1);
               r_in     = n_ff[5:0];
               state_in = S_CHR_NEXT;
            end
         end
         S_CHR_NEXT: begin
            // Also catches a label whose last character ends the message.
            if (alu_ge) begin
               state_in = S_FAIL;
            end else if (r_ff == '0) begin
               state_in = S_HEAD_CHK;
            end else begin
               r_in     = r_ff - 6'd1;
               state_in = S_CHR;
            end
         end
         S_CHR: begin
            if (rd_data == dnd_pkg::CHAR_DOT) begin
               if (alu_ge) begin
                  state_in = S_FAIL;
               end else if (out_free) begin
                  push_en   = 1'b1;
                  push_char = dnd_pkg::CHAR_ESC;
                  rp_in     = rp_ff + PW'(1);
                  state_in  = S_ESC;
               end
            end else if (out_free) begin
               push_en  = 1'b1;
               rp_in    = rp_ff + PW'(1);
               state_in = S_CHR_NEXT;
            end
         end
         S_ESC: begin
            if (out_free) begin
               push_en   = 1'b1;
               push_char = dnd_pkg::CHAR_DOT;
               state_in  = S_CHR_NEXT;
            end
         end
         S_PTR: begin
            if (alu_ge) begin
               state_in = S_FAIL;
            end else begin
               rp_in    = target;
               chk_in   = chk_ff + CW'(2);
               state_in = S_PTR_CHK;
            end
         end
         S_PTR_CHK: begin
            state_in = alu_ge ? S_FAIL : S_HEAD_CHK;
         end
         S_FINAL: begin
            if (out_free) begin
               emit_en   = 1'b1;
               emit_word = acc_ff;
               emit_cnt  = {1'b0, accn_ff};
               emit_cons = (cons_raw > PW'(dnd_pkg::CONS_MAX)) ?
                           dnd_pkg::CONS_MAX : cons_raw[dnd_pkg::CONS_W-1:0];
               state_in  = S_IDLE;
            end
         end
         S_FAIL: begin
            if (out_free) begin
               emit_en     = 1'b1;
               emit_status = dnd_pkg::STATUS_ERR;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (push_en) begin
         oc_in = oc_ff + OCW'(1);
         if (accn_ff == '1) begin
            emit_en   = 1'b1;
            emit_word = word_set;
            emit_cnt  = dnd_pkg::FULL_COUNT;
            emit_last = 1'b0;
            acc_in    = '0;
            accn_in   = '0;
         end else begin
            acc_in  = word_set;
            accn_in = accn_ff + dnd_pkg::LANE_W'(1);
         end
      end
   end

   // Response register; the sequencer only emits when it is free.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      out_cnt_in    = out_cnt_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      out_cons_in   = out_cons_ff;
      if (emit_en) begin
         out_valid_in  = 1'b1;
         out_word_in   = emit_word;
         out_cnt_in    = emit_cnt;
         out_last_in   = emit_last;
         out_status_in = emit_status;
         out_cons_in   = emit_cons;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         fp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         fp_valid_ff  <= fp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rp_ff         <= rp_in;
      start_ff      <= start_in;
      oc_ff         <= oc_in;
      chk_ff        <= chk_in;
      fp_len_ff     <= fp_len_in;
      acc_ff        <= acc_in;
      accn_ff       <= accn_in;
      n_ff          <= n_in;
      r_ff          <= r_in;
      out_word_ff   <= out_word_in;
      out_cnt_ff    <= out_cnt_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
      out_cons_ff   <= out_cons_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.text_word  = out_word_ff;
   assign rsp_ch.char_count = out_cnt_ff;
   assign rsp_ch.last       = out_last_ff;
   assign rsp_ch.status     = out_status_ff;
   assign rsp_ch.consumed   = out_cons_ff;

endmodule

>>> rtl/dns_name_decompress_top.sv
// Loads may follow back to back. Expand: each length byte takes a bounds check, a store
// read and a decode; a label adds a length check, the separating dot after the first
// label, an end check and a push per character, an extra push per escaped dot and a
// closing end check; a pointer adds a target and a loop check; last comes the result.
// Not ready during an expansion; stalls on the response channel hold the walk.
// Synchronous reset clears control state and the loaded length; store undefined.
module dns_name_decompress_top #(
   parameter int MSG_BYTES  = 512,
   parameter int NAME_LIMIT = 255
) (
   input  logic        clock,
   input  logic        reset,
   dnd_req_if.sink     req_ch,
   dnd_rsp_if.source   rsp_ch
);
   localparam int AW = $clog2(MSG_BYTES);
   localparam int LW = $clog2(MSG_BYTES + 1);

   dnd_pkg::load_type            load;
   logic [AW-1:0]                rd_addr;
   logic [dnd_pkg::DATA_W-1:0]   rd_data;
   logic [LW-1:0]                msg_len;

   dnd_store #(.MSG_BYTES(MSG_BYTES)) u_store (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .msg_len (msg_len)
   );

   dnd_walk #(.MSG_BYTES(MSG_BYTES), .NAME_LIMIT(NAME_LIMIT)) u_walk (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .load    (load),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .msg_len (msg_len)
   );

endmodule

>>> dv/dns_name_decompress_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for dns_name_decompress_top: loads DNS messages, expands names
// from them and checks each response word against a predictor kept in this file.
// Depends on rtl/dnd_pkg.sv, rtl/dnd_if.sv and rtl/dns_name_decompress_top.sv.
module dns_name_decompress_top_tb;

   localparam int MSG_BYTES    = 512;
   localparam int NAME_LIMIT   = 255;
   localparam int OUT_LIMIT    = (NAME_LIMIT < 256) ? NAME_LIMIT : 256;
   localparam int RANDOM_ITEMS = 250;
   localparam int MIN_EXPANDS  = 40;
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 64;

   localparam logic [1:0] LT_RESERVED_LO = 2'b01;
   localparam logic [1:0] LT_RESERVED_HI = 2'b10;

   typedef struct packed {
      logic                        cmd;
      logic                        first;
      logic [dnd_pkg::DATA_W-1:0]  data_byte;
      logic [dnd_pkg::START_W-1:0] start_offset;
   } request_type;

   typedef struct packed {
      logic [dnd_pkg::TEXT_W-1:0]  text_word;
      logic [dnd_pkg::COUNT_W-1:0] char_count;
      logic                        last;
      logic                        status;
      logic [dnd_pkg::CONS_W-1:0]  consumed;
   } name_word_type;

   typedef struct packed {
      request_type   rq;
      logic          typed;
      name_word_type word;
   } stim_row_type;

   logic clock;
   logic reset;

   dnd_req_if req_ch();
   dnd_rsp_if rsp_ch();

   dns_name_decompress_top #(
      .MSG_BYTES  (MSG_BYTES),
      .NAME_LIMIT (NAME_LIMIT)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Predictor state: the loaded packet image and the word being assembled.
   logic [dnd_pkg::DATA_W-1:0] packet_image [MSG_BYTES];
   int unsigned                image_length = 0;
   logic [dnd_pkg::TEXT_W-1:0] word_acc;
   int unsigned                word_fill;
   int unsigned                name_chars;
   name_word_type              expected_words [$];

   // Random message under construction.
   logic [dnd_pkg::DATA_W-1:0] message_bytes [$];
   int                         name_starts [$];
   int                         label_starts [$];

   int idle_mode    = 0;
   int error_count  = 0;
   int stall_cycles = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic stim_row_type load_row(input logic first,
                                             input logic [dnd_pkg::DATA_W-1:0] data);
      stim_row_type row;
      row = '0;
      row.rq.cmd          = dnd_pkg::CMD_LOAD;
      row.rq.first        = first;
      row.rq.data_byte    = data;
      row.rq.start_offset = dnd_pkg::START_W'($urandom_range(511));
      return row;
   endfunction

   function automatic stim_row_type expand_row(input logic [dnd_pkg::START_W-1:0] start);
      stim_row_type row;
      row = '0;
      row.rq.cmd          = dnd_pkg::CMD_EXPAND;
      row.rq.first        = 1'($urandom_range(1));
      row.rq.data_byte    = dnd_pkg::DATA_W'($urandom_range(255));
      row.rq.start_offset = start;
      return row;
   endfunction

   // Expand whose single final result is known without walking the name.
   function automatic stim_row_type known_row(input logic [dnd_pkg::START_W-1:0] start,
                                              input logic status,
                                              input logic [dnd_pkg::CONS_W-1:0] cons);
      stim_row_type row;
      row = expand_row(start);
      row.typed = 1'b1;
      row.word  = '{'0, '0, 1'b1, status, cons};
      return row;
   endfunction

   task automatic append_char(input logic [dnd_pkg::DATA_W-1:0] ch);
      word_acc[8*word_fill +: 8] = ch;
      word_fill++;
      name_chars++;
      if (word_fill == 8) begin
         expected_words.push_back('{word_acc, dnd_pkg::FULL_COUNT, 1'b0,
                                    dnd_pkg::STATUS_OK, '0});
         word_acc  = '0;
         word_fill = 0;
      end
   endtask

   task automatic predict_expand(input logic [dnd_pkg::START_W-1:0] start);
      int unsigned                start_pos, pos, checked, first_ptr_len, rest, target, cons_len;
      logic [dnd_pkg::DATA_W-1:0] len_byte, ch, low_byte;
      bit                         ptr_seen, failed, finished;
      start_pos  = start;
      pos        = start;
      checked    = 0;
      first_ptr_len = 0;
      ptr_seen   = 1'b0;
      failed     = 1'b0;
      finished   = 1'b0;
      word_acc   = '0;
      word_fill  = 0;
      name_chars = 0;
      while (!failed && !finished) begin
         if (pos >= image_length) begin
            failed = 1'b1;
         end else begin
            len_byte = packet_image[pos];
            pos++;
            if (len_byte == dnd_pkg::BYTE_ZERO) begin
               finished = 1'b1;
            end else if (len_byte[7:6] == dnd_pkg::LT_LABEL) begin
               if (name_chars != 0) begin
                  if (name_chars >= OUT_LIMIT) failed = 1'b1;
                  else append_char(dnd_pkg::CHAR_DOT);
               end
               if (!failed && name_chars + len_byte >= OUT_LIMIT) failed = 1'b1;
               checked += len_byte + 1;
               rest = len_byte;
               while (!failed && rest > 0) begin
                  rest--;
                  if (pos >= image_length) begin
                     failed = 1'b1;
                  end else begin
                     ch = packet_image[pos];
                     pos++;
                     // A dot inside a label needs room for its escape as well.
                     if (ch == dnd_pkg::CHAR_DOT) begin
                        if (name_chars + rest + 2 >= OUT_LIMIT) failed = 1'b1;
                        else append_char(dnd_pkg::CHAR_ESC);
                     end
                     if (!failed) begin
                        append_char(ch);
                        if (pos >= image_length) failed = 1'b1;
                     end
                  end
               end
            end else if (len_byte[7:6] == dnd_pkg::LT_POINTER) begin
               if (!ptr_seen) begin
                  first_ptr_len = pos - start_pos + 1;
                  ptr_seen      = 1'b1;
               end
               if (pos >= image_length) begin
                  failed = 1'b1;
               end else begin
                  low_byte = packet_image[pos];
                  target   = {len_byte[5:0], low_byte};
                  if (target >= image_length) begin
                     failed = 1'b1;
                  end else begin
                     pos     = target;
                     checked += 2;
                     if (checked >= image_length) failed = 1'b1;
                  end
               end
            end else begin
               failed = 1'b1;
            end
         end
      end
      if (failed) begin
         expected_words.push_back('{'0, '0, 1'b1, dnd_pkg::STATUS_ERR, '0});
      end else begin
         cons_len = ptr_seen ? first_ptr_len : pos - start_pos;
         if (cons_len > dnd_pkg::CONS_MAX) cons_len = dnd_pkg::CONS_MAX;
         expected_words.push_back('{word_acc, dnd_pkg::COUNT_W'(word_fill), 1'b1,
                                    dnd_pkg::STATUS_OK, dnd_pkg::CONS_W'(cons_len)});
      end
   endtask

   task automatic send_request(input stim_row_type row);
      while (idle_mode < 2 && $urandom_range(99) < (idle_mode == 0 ? 27 : 68)) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= row.rq.cmd;
      req_ch.first        <= row.rq.first;
      req_ch.data_byte    <= row.rq.data_byte;
      req_ch.start_offset <= row.rq.start_offset;
      do @(posedge clock); while (!req_ch.ready);
      if (row.rq.cmd == dnd_pkg::CMD_LOAD) begin
         if (row.rq.first) image_length = 0;
         if (image_length < MSG_BYTES) begin
            packet_image[image_length] = row.rq.data_byte;
            image_length++;
         end
      end else if (row.typed) begin
         expected_words.push_back(row.word);
      end else begin
         predict_expand(row.rq.start_offset);
      end
   endtask

   task automatic build_message(input int pad_to);
      int   shape, names, labels, len, prior, pool, target, sel;
      bit   long_name;
      logic [dnd_pkg::DATA_W-1:0] ch;
      message_bytes.delete();
      name_starts.delete();
      label_starts.delete();
      shape = $urandom_range(99);
      if (shape < 8) begin
         repeat ($urandom_range(40, 1))
            message_bytes.push_back(dnd_pkg::DATA_W'($urandom_range(255)));
      end else begin
         names = $urandom_range(3, 1);
         for (int i = 0; i < names; i++) begin
            prior = label_starts.size();
            name_starts.push_back(message_bytes.size());
            long_name = ($urandom_range(99) < 8);
            labels = long_name ? $urandom_range(5, 4) : $urandom_range(3, 0);
            for (int l = 0; l < labels; l++) begin
               if (long_name) len = $urandom_range(63, 56);
               else if ($urandom_range(99) < 10) len = $urandom_range(63, 11);
               else len = $urandom_range(10, 1);
               if (message_bytes.size() + len > 440) break;
               label_starts.push_back(message_bytes.size());
               message_bytes.push_back(len[7:0]);
               for (int k = 0; k < len; k++) begin
                  sel = $urandom_range(99);
                  if (sel < 15) ch = dnd_pkg::CHAR_DOT;
                  else if (sel < 30) ch = dnd_pkg::DATA_W'($urandom_range(255));
                  else ch = dnd_pkg::DATA_W'(8'h61 + $urandom_range(25));
                  message_bytes.push_back(ch);
               end
            end
            // Mostly point back to an earlier name; now and then into this one, a loop.
            pool = ($urandom_range(99) < 10) ? label_starts.size() : prior;
            if (pool != 0 && $urandom_range(99) < 40) begin
               target = label_starts[$urandom_range(pool - 1)];
               message_bytes.push_back({dnd_pkg::LT_POINTER, 6'(target >> 8)});
               message_bytes.push_back(target[7:0]);
            end else begin
               message_bytes.push_back(dnd_pkg::BYTE_ZERO);
            end
         end
         if (shape < 16) begin
            message_bytes[$urandom_range(message_bytes.size() - 1)] =
               dnd_pkg::DATA_W'($urandom_range(255));
         end else if (shape < 24) begin
            repeat ($urandom_range(3, 1))
               if (message_bytes.size() > 1) void'(message_bytes.pop_back());
         end
      end
      while (message_bytes.size() < pad_to)
         message_bytes.push_back(dnd_pkg::DATA_W'($urandom_range(255)));
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      name_word_type got, want;
      if (rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.text_word, rsp_ch.char_count, rsp_ch.last, rsp_ch.status,
                 rsp_ch.consumed};
         if (expected_words.size() == 0) begin
            $error("response transaction with nothing expected: text_word %h last %b",
                   got.text_word, got.last);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            compare_field("text_word", want.text_word, got.text_word);
            compare_field("char_count", want.char_count, got.char_count);
            compare_field("last", want.last, got.last);
            compare_field("status", want.status, got.status);
            compare_field("consumed", want.consumed, got.consumed);
         end
      end
      case (idle_mode)
         0: rsp_ch.ready <= ($urandom_range(99) >= 68);
         1: rsp_ch.ready <= ($urandom_range(99) >= 27);
         default: rsp_ch.ready <= 1'b1;
      endcase
   end

   // Any transaction on either channel counts as progress.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("dns_name_decompress_top_tb: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      stim_row_type directed_rows [$];
      int           random_items, expands_sent, base, expands, sel, offset;
      bit           append;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.cmd          <= dnd_pkg::CMD_LOAD;
      req_ch.first        <= 1'b0;
      req_ch.data_byte    <= '0;
      req_ch.start_offset <= '0;

      // Message built up below: 01 2E C0 00 40 80 FF 3F 00 C0 08 FF.
      directed_rows.push_back(known_row(9'd0, dnd_pkg::STATUS_ERR, 9'd0));   // nothing loaded
      directed_rows.push_back(load_row(1'b1, dnd_pkg::BYTE_ZERO));
      directed_rows.push_back(known_row(9'd0, dnd_pkg::STATUS_OK, 9'd1));    // root name
      directed_rows.push_back(known_row(9'd511, dnd_pkg::STATUS_ERR, 9'd0)); // past the end
      directed_rows.push_back(load_row(1'b1, 8'd1));
      directed_rows.push_back(load_row(1'b0, dnd_pkg::CHAR_DOT));
      directed_rows.push_back(load_row(1'b0, {dnd_pkg::LT_POINTER, 6'd0}));
      directed_rows.push_back(load_row(1'b0, dnd_pkg::BYTE_ZERO));
      directed_rows.push_back(expand_row(9'd0));                      // escaped dot, loop
      directed_rows.push_back(expand_row(9'd2));
      directed_rows.push_back(load_row(1'b0, {LT_RESERVED_LO, 6'd0}));
      directed_rows.push_back(expand_row(9'd4));
      directed_rows.push_back(load_row(1'b0, {LT_RESERVED_HI, 6'd0}));
      directed_rows.push_back(expand_row(9'd5));
      directed_rows.push_back(load_row(1'b0, {dnd_pkg::LT_POINTER, 6'h3F}));
      directed_rows.push_back(expand_row(9'd6));                      // pointer cut short
      directed_rows.push_back(load_row(1'b0, 8'h3F));
      directed_rows.push_back(expand_row(9'd6));                      // target out of range
      directed_rows.push_back(load_row(1'b0, dnd_pkg::BYTE_ZERO));
      directed_rows.push_back(expand_row(9'd7));                      // label hits the end
      directed_rows.push_back(load_row(1'b0, {dnd_pkg::LT_POINTER, 6'd0}));
      directed_rows.push_back(load_row(1'b0, 8'd8));
      directed_rows.push_back(expand_row(9'd9));                      // pointer to root
      directed_rows.push_back(load_row(1'b0, 8'hFF));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_request(directed_rows[i]);

      random_items = 0;
      expands_sent = 0;
      while (random_items < RANDOM_ITEMS || expands_sent < MIN_EXPANDS) begin
         build_message(0);
         append = image_length != 0 && $urandom_range(99) < 5
                  && image_length + message_bytes.size() <= MSG_BYTES;
         base = append ? image_length : 0;
         foreach (message_bytes[i])
            send_request(load_row(i == 0 && !append, message_bytes[i]));
         random_items += message_bytes.size();
         expands = $urandom_range(8, 3);
         for (int e = 0; e < expands; e++) begin
            sel = $urandom_range(99);
            if (sel < 55 && name_starts.size() != 0)
               offset = base + name_starts[$urandom_range(name_starts.size() - 1)];
            else if (sel < 70 && label_starts.size() != 0)
               offset = base + label_starts[$urandom_range(label_starts.size() - 1)];
            else if (sel < 95)
               offset = $urandom_range(image_length + 1);
            else
               offset = $urandom_range(511);
            send_request(expand_row(offset[dnd_pkg::START_W-1:0]));
         end
         random_items += expands;
         expands_sent += expands;
         if (random_items >= 2 * RANDOM_ITEMS / 3) idle_mode = 2;
         else if (random_items >= RANDOM_ITEMS / 3) idle_mode = 1;
      end

      req_ch.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("dns_name_decompress_top_tb: PASS");
      else $display("dns_name_decompress_top_tb: FAIL");
      $finish;
   end

endmodule

>>> files.f
rtl/dnd_pkg.sv
rtl/dnd_if.sv
rtl/dnd_store.sv
rtl/dnd_alu.sv
rtl/dnd_walk.sv
rtl/dns_name_decompress_top.sv
dv/dns_name_decompress_top_tb.sv
